// File: sv/dos_pkg.sv
// Package with shared constants, types and a helper function of the DHCP option scanner.
package dos_pkg;

    // Message layout.
    localparam int MAX_FRAME_BYTES = 2048;
    localparam int HEADER_BYTES    = 236;
    localparam int POS_W           = $clog2(MAX_FRAME_BYTES + 1);

    // Option codes with a fixed meaning.
    localparam logic [7:0] OPT_PAD      = 8'd0;
    localparam logic [7:0] OPT_MSG_TYPE = 8'd53;
    localparam logic [7:0] OPT_END      = 8'd255;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 12;
    localparam logic [CFG_IDX_W-1:0] CFG_WANTED_OPTION = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_LENGTH    = 2'd1;

    localparam logic [7:0]            WANTED_RESET  = 8'd54;
    localparam logic [CFG_DATA_W-1:0] MIN_LEN_RESET = 12'd240;

    // Queue between front and back.
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

    // Role of a byte, settled by its position in the message.
    typedef enum logic [1:0] {
        KIND_NONE   = 2'd0,
        KIND_XID    = 2'd1,
        KIND_COOKIE = 2'd2,
        KIND_OPT    = 2'd3
    } dos_kind_t;

    // One classified word handed from front to back.
    typedef struct packed {
        logic [7:0] data;
        logic       last;
        dos_kind_t  kind;
        logic [1:0] sub;
        logic       len_ok;
    } dos_entry_t;

    // One result word.
    typedef struct packed {
        logic        is_dhcp;
        logic [31:0] transaction_id;
        logic        type_found;
        logic [7:0]  message_type;
        logic        option_found;
        logic        option_too_large;
        logic [31:0] option_value;
        logic        end_seen;
    } dos_result_t;

    // Option walk phase.
    typedef enum logic [2:0] {
        PH_CODE  = 3'b001,
        PH_LEN   = 3'b010,
        PH_VALUE = 3'b100
    } dos_phase_t;

    // Magic cookie byte at a given offset after the header.
    function automatic logic [7:0] cookie_byte(input logic [1:0] idx);
        logic [7:0] b;
        case (idx)
            2'd0:    b = 8'h63;
            2'd1:    b = 8'h82;
            2'd2:    b = 8'h53;
            default: b = 8'h63;
        endcase
        return b;
    endfunction

endpackage

// File: sv/dos_front.sv
// Front part: accepts message bytes, tracks the byte position and classifies each byte.
module dos_front
    import dos_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [7:0]            data_byte,
    input  logic                  last,
    input  logic [CFG_DATA_W-1:0] min_length,
    input  logic                  fifo_full,
    output logic                  push,
    output dos_entry_t            entry
);

    localparam logic [POS_W-1:0] XID_FIRST    = POS_W'(4);
    localparam logic [POS_W-1:0] XID_END      = POS_W'(8);
    localparam logic [POS_W-1:0] COOKIE_FIRST = POS_W'(HEADER_BYTES);
    localparam logic [POS_W-1:0] COOKIE_END   = POS_W'(HEADER_BYTES + 4);
    localparam logic [POS_W-1:0] POS_MAX      = POS_W'(MAX_FRAME_BYTES);

    logic [POS_W-1:0] pos_reg;
    logic [POS_W-1:0] pos_next;
    logic [POS_W-1:0] pos_inc;
    logic [POS_W-1:0] cookie_off;

    assign in_ready = !fifo_full;
    assign push     = in_valid && !fifo_full;

    // Position after this byte, held at the frame maximum.
    assign pos_inc    = (pos_reg < POS_MAX) ? pos_reg + POS_W'(1) : pos_reg;
    assign cookie_off = pos_reg - COOKIE_FIRST;

    // Classify the byte by where it sits in the message.
    always_comb
    begin
        entry.data   = data_byte;
        entry.last   = last;
        entry.kind   = KIND_NONE;
        entry.sub    = 2'd0;
        entry.len_ok = (POS_W'(pos_inc) >= POS_W'(min_length)) && (pos_inc >= COOKIE_END)
                       && ({1'b0, pos_inc} >= {1'b0, min_length});
        if (pos_reg >= XID_FIRST && pos_reg < XID_END)
        begin
            entry.kind = KIND_XID;
            entry.sub  = pos_reg[1:0];
        end
        else if (pos_reg >= COOKIE_FIRST && pos_reg < COOKIE_END)
        begin
            entry.kind = KIND_COOKIE;
            entry.sub  = cookie_off[1:0];
        end
        else if (pos_reg >= COOKIE_END)
        begin
            entry.kind = KIND_OPT;
        end
    end

    // The position restarts after the final byte of a message.
    always_comb
    begin
        pos_next = pos_reg;
        if (push)
        begin
            pos_next = last ? '0 : pos_inc;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
        end
        else
        begin
            pos_reg <= pos_next;
        end
    end

endmodule

// File: sv/dos_fifo.sv
// Short queue of classified words between the front and back parts.
module dos_fifo
    import dos_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       wr_en,
    input  dos_entry_t wr_data,
    output logic       full,
    input  logic       rd_en,
    output logic       rd_valid,
    output dos_entry_t rd_data
);

    dos_entry_t            mem_reg [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] wr_ptr_reg;
    logic [FIFO_PTR_W-1:0] wr_ptr_next;
    logic [FIFO_PTR_W-1:0] rd_ptr_reg;
    logic [FIFO_PTR_W-1:0] rd_ptr_next;
    logic [FIFO_CNT_W-1:0] count_reg;
    logic [FIFO_CNT_W-1:0] count_next;
    logic                  do_push;
    logic                  do_pop;

    assign full     = (count_reg == FIFO_CNT_W'(FIFO_DEPTH));
    assign rd_valid = (count_reg != '0);
    assign rd_data  = mem_reg[rd_ptr_reg];
    assign do_push  = wr_en && !full;
    assign do_pop   = rd_en && rd_valid;

    // Pointer and fill count updates.
    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + FIFO_PTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + FIFO_PTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + FIFO_CNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - FIFO_CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage needs no reset.
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FIFO_CNT_W'(FIFO_DEPTH))
        else $error("queue fill count beyond depth");
    a_count_up: assert property (@(posedge clk) disable iff (!rst_n)
        do_push && !do_pop |=> count_reg == $past(count_reg) + FIFO_CNT_W'(1))
        else $error("queue count did not grow on push");
    a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != FIFO_CNT_W'(FIFO_DEPTH)) |->
        (FIFO_PTR_W'(wr_ptr_reg - rd_ptr_reg) == count_reg[FIFO_PTR_W-1:0]))
        else $error("queue pointers disagree with fill count");
`endif

endmodule

// File: sv/dos_back.sv
// Back part: checks the cookie, walks the option TLVs and builds the result word.
module dos_back
    import dos_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic [7:0]  wanted_option,
    input  logic        q_valid,
    input  dos_entry_t  q_data,
    output logic        q_pop,
    output logic        out_valid,
    input  logic        out_ready,
    output dos_result_t result
);

    logic        cookie_ok_reg,  cookie_ok_next;
    logic [31:0] xid_reg,        xid_next;
    dos_phase_t  phase_reg,      phase_next;
    logic [7:0]  code_reg,       code_next;
    logic [7:0]  left_reg,       left_next;
    logic [1:0]  vidx_reg,       vidx_next;
    logic        f_type_reg,     f_type_next;
    logic        f_opt_reg,      f_opt_next;
    logic        f_big_reg,      f_big_next;
    logic        f_end_reg,      f_end_next;
    logic [7:0]  type_reg,       type_next;
    logic [31:0] value_reg,      value_next;
    logic        grab_type_reg,  grab_type_next;
    logic        grab_value_reg, grab_value_next;
    logic        out_valid_reg,  out_valid_next;
    dos_result_t result_reg,     result_next;
    logic        slot_free;
    logic        finish;
    logic        dhcp;

    // A final word waits until the output register can take its result.
    assign slot_free = !out_valid_reg || out_ready;
    assign q_pop     = q_valid && (!q_data.last || slot_free);
    assign finish    = q_pop && q_data.last;
    assign out_valid = out_valid_reg;
    assign result    = result_reg;

    // Per-word state update.
    always_comb
    begin
        cookie_ok_next  = cookie_ok_reg;
        xid_next        = xid_reg;
        phase_next      = phase_reg;
        code_next       = code_reg;
        left_next       = left_reg;
        vidx_next       = vidx_reg;
        f_type_next     = f_type_reg;
        f_opt_next      = f_opt_reg;
        f_big_next      = f_big_reg;
        f_end_next      = f_end_reg;
        type_next       = type_reg;
        value_next      = value_reg;
        grab_type_next  = grab_type_reg;
        grab_value_next = grab_value_reg;
        if (q_pop)
        begin
            case (q_data.kind)
                KIND_XID:
                begin
                    xid_next = xid_reg | (32'(q_data.data) << {q_data.sub, 3'b000});
                end
                KIND_COOKIE:
                begin
                    if (q_data.data != cookie_byte(q_data.sub))
                    begin
                        cookie_ok_next = 1'b0;
                    end
                end
                KIND_OPT:
                begin
                    if (!f_end_reg)
                    begin
                        case (phase_reg)
                            PH_CODE:
                            begin
                                if (q_data.data == OPT_END)
                                begin
                                    f_end_next = 1'b1;
                                end
                                else if (q_data.data != OPT_PAD)
                                begin
                                    code_next  = q_data.data;
                                    phase_next = PH_LEN;
                                end
                            end
                            PH_LEN:
                            begin
                                left_next       = q_data.data;
                                vidx_next       = 2'd0;
                                grab_type_next  = (code_reg == OPT_MSG_TYPE) &&
                                                  (q_data.data == 8'd1) && !f_type_reg;
                                grab_value_next = 1'b0;
                                if (code_reg == wanted_option && !f_opt_reg)
                                begin
                                    f_opt_next = 1'b1;
                                    if (q_data.data > 8'd4)
                                    begin
                                        f_big_next = 1'b1;
                                        value_next = '0;
                                    end
                                    else
                                    begin
                                        grab_value_next = 1'b1;
                                    end
                                end
                                phase_next = (q_data.data == 8'd0) ? PH_CODE : PH_VALUE;
                            end
                            PH_VALUE:
                            begin
                                if (grab_type_reg)
                                begin
                                    type_next      = q_data.data;
                                    f_type_next    = 1'b1;
                                    grab_type_next = 1'b0;
                                end
                                if (grab_value_reg)
                                begin
                                    value_next = value_reg |
                                                 (32'(q_data.data) << {vidx_reg, 3'b000});
                                    vidx_next  = vidx_reg + 2'd1;
                                end
                                left_next = left_reg - 8'd1;
                                if (left_reg == 8'd1)
                                begin
                                    phase_next      = PH_CODE;
                                    grab_type_next  = 1'b0;
                                    grab_value_next = 1'b0;
                                end
                            end
                            default:
                            begin
                                phase_next = PH_CODE;
                            end
                        endcase
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // Result of a message, all zero when it is not DHCP.
    always_comb
    begin
        dhcp        = cookie_ok_next && q_data.len_ok;
        result_next = '0;
        if (dhcp)
        begin
            result_next.is_dhcp          = 1'b1;
            result_next.transaction_id   = xid_next;
            result_next.type_found       = f_type_next;
            result_next.message_type     = f_type_next ? type_next : 8'd0;
            result_next.option_found     = f_opt_next;
            result_next.option_too_large = f_big_next;
            result_next.option_value     = f_big_next ? 32'd0 : value_next;
            result_next.end_seen         = f_end_next;
        end
        out_valid_next = finish ? 1'b1 : (out_ready ? 1'b0 : out_valid_reg);
    end

    // Message state, cleared after each final word.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cookie_ok_reg  <= 1'b1;
            xid_reg        <= '0;
            phase_reg      <= PH_CODE;
            code_reg       <= '0;
            left_reg       <= '0;
            vidx_reg       <= '0;
            f_type_reg     <= 1'b0;
            f_opt_reg      <= 1'b0;
            f_big_reg      <= 1'b0;
            f_end_reg      <= 1'b0;
            type_reg       <= '0;
            value_reg      <= '0;
            grab_type_reg  <= 1'b0;
            grab_value_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (finish)
            begin
                cookie_ok_reg  <= 1'b1;
                xid_reg        <= '0;
                phase_reg      <= PH_CODE;
                code_reg       <= '0;
                left_reg       <= '0;
                vidx_reg       <= '0;
                f_type_reg     <= 1'b0;
                f_opt_reg      <= 1'b0;
                f_big_reg      <= 1'b0;
                f_end_reg      <= 1'b0;
                type_reg       <= '0;
                value_reg      <= '0;
                grab_type_reg  <= 1'b0;
                grab_value_reg <= 1'b0;
            end
            else
            begin
                cookie_ok_reg  <= cookie_ok_next;
                xid_reg        <= xid_next;
                phase_reg      <= phase_next;
                code_reg       <= code_next;
                left_reg       <= left_next;
                vidx_reg       <= vidx_next;
                f_type_reg     <= f_type_next;
                f_opt_reg      <= f_opt_next;
                f_big_reg      <= f_big_next;
                f_end_reg      <= f_end_next;
                type_reg       <= type_next;
                value_reg      <= value_next;
                grab_type_reg  <= grab_type_next;
                grab_value_reg <= grab_value_next;
            end
        end
    end

    // Output payload register.
    always_ff @(posedge clk)
    begin
        if (finish)
        begin
            result_reg <= result_next;
        end
    end

`ifndef ASSERT_OFF
    a_finish_shows: assert property (@(posedge clk) disable iff (!rst_n)
        finish |=> out_valid_reg)
        else $error("final word did not produce a result");
    a_big_has_opt: assert property (@(posedge clk) disable iff (!rst_n)
        f_big_reg |-> f_opt_reg)
        else $error("too-large flag without option flag");
    a_type_clean: assert property (@(posedge clk) disable iff (!rst_n)
        !f_type_reg |-> type_reg == 8'd0)
        else $error("message type stored without its flag");
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_ready |-> !finish)
        else $error("pending result overwritten");
`endif

endmodule

// File: sv/dhcp_option_scanner_core.sv
// Top level of the DHCP option scanner: configuration registers and the front, queue and back.
//
// Usage: message bytes enter on data_byte, one word per cycle, from the first byte on, with
// last high on the final byte; a word is taken when in_valid and in_ready are both high.
// One result word leaves on out_valid/out_ready after each final byte: is_dhcp, the
// transaction id, message type, the wanted option's value and flags, and end_seen.
// The front counts byte positions and tags each byte (transaction id, cookie or option);
// a four-word queue passes tagged words to the back, which walks the option TLVs.
// Throughput is one byte per cycle while the queue is not full; the back's option walk takes a word on every pop.
// The final byte is written into the queue; the back pops it and registers the result in the
// output register, without waiting when the queue is empty and the output register is free.
// When the receiver stalls, the back keeps working on bytes of the next message and
// only holds at that message's final byte; in_ready drops once the queue fills.
// Reset (rst_n low, asynchronous) empties the queue and output register, clears all
// message state, and sets wanted_option to 54 and min_length to 240.
// Configuration: cfg_we writes cfg_data to register cfg_index (0 wanted_option,
// 1 min_length) at once; write only while no message is in flight.
module dhcp_option_scanner_core
    import dos_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [7:0]            data_byte,
    input  logic                  last,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic                  is_dhcp,
    output logic [31:0]           transaction_id,
    output logic                  type_found,
    output logic [7:0]            message_type,
    output logic                  option_found,
    output logic                  option_too_large,
    output logic [31:0]           option_value,
    output logic                  end_seen
);

    logic [7:0]            wanted_reg;
    logic [CFG_DATA_W-1:0] min_len_reg;
    logic                  fifo_full;
    logic                  push;
    dos_entry_t            entry;
    logic                  q_valid;
    dos_entry_t            q_data;
    logic                  q_pop;
    dos_result_t           result;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wanted_reg  <= WANTED_RESET;
            min_len_reg <= MIN_LEN_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_WANTED_OPTION: wanted_reg  <= cfg_data[7:0];
                CFG_MIN_LENGTH:    min_len_reg <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    dos_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .data_byte  (data_byte),
        .last       (last),
        .min_length (min_len_reg),
        .fifo_full  (fifo_full),
        .push       (push),
        .entry      (entry)
    );

    dos_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (push),
        .wr_data  (entry),
        .full     (fifo_full),
        .rd_en    (q_pop),
        .rd_valid (q_valid),
        .rd_data  (q_data)
    );

    dos_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .wanted_option (wanted_reg),
        .q_valid       (q_valid),
        .q_data        (q_data),
        .q_pop         (q_pop),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .result        (result)
    );

    assign is_dhcp          = result.is_dhcp;
    assign transaction_id   = result.transaction_id;
    assign type_found       = result.type_found;
    assign message_type     = result.message_type;
    assign option_found     = result.option_found;
    assign option_too_large = result.option_too_large;
    assign option_value     = result.option_value;
    assign end_seen         = result.end_seen;

endmodule
